>>> design/rsit_pkg.sv
// shared types and constants for the sorted insert table
package rsit_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int CountW = $clog2(TABLE_DEPTH + 1);
  localparam int RankW = 6;

  localparam logic [1:0] CMD_INSERT      = 2'd0;
  localparam logic [1:0] CMD_INSERT_EMIT = 2'd1;
  localparam logic [1:0] CMD_EMIT        = 2'd2;

  typedef struct packed {
    logic signed [7:0] strength;
    logic [7:0]        ap_id;
  } entry_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [7:0] strength;
    logic [7:0]        ap_id;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        ap_id_out;
    logic signed [7:0] strength_out;
    logic [RankW-1:0]  rank;
    logic              final_res;
  } out_word_t;

  typedef struct packed {
    logic   ins;
    logic   drain;
    entry_t new_ent;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

>>> design/rssi_sorted_insert_table_core.sv
// top level: row of table cells, fill count, drain sequencer and output register
//
//  channel | signals                        | accepted when
//  in      | in_valid, in_ready, in_word    | in_valid && in_ready
//  out     | out_valid, out_ready, out_word | out_valid && out_ready
//
// an insert has every cell compare with the new record at once
// and the row shifts right by one behind the insertion point
// an emit drains the row through cell 0 into the output register, one entry per
// cycle while the output is not stalled, until every stored entry is out
// in_ready is low while draining; a stalled output holds the row in place
// reset clears the fill count and the sequencer; slot contents are not reset
module rssi_sorted_insert_table_core
  import rsit_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  state_t           state, state_next;
  logic [CountW-1:0] count, count_next;
  logic [RankW-1:0] rank, rank_next;
  logic             accept, do_ins, emit_req, load_out;
  cell_ctl_t        ctl;

  logic   [TABLE_DEPTH-1:0] take;
  logic   [TABLE_DEPTH-1:0] prev_take;
  logic   [TABLE_DEPTH-1:0] is_valid;
  entry_t                   ents [TABLE_DEPTH];
  entry_t                   prev_ents [TABLE_DEPTH];
  entry_t                   next_ents [TABLE_DEPTH];

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign do_ins   = accept && (in_word.cmd == CMD_INSERT || in_word.cmd == CMD_INSERT_EMIT);
  assign emit_req = in_word.cmd != CMD_INSERT;
  assign load_out = (state == ST_DRAIN) && (!out_valid || out_ready);

  assign ctl.ins              = do_ins;
  assign ctl.drain            = load_out;
  assign ctl.new_ent.strength = in_word.strength;
  assign ctl.new_ent.ap_id    = in_word.ap_id;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      assign is_valid[gi] = CountW'(gi) < count;
      if (gi == 0) begin : g_first
        assign prev_take[gi] = 1'b0;
        assign prev_ents[gi] = ctl.new_ent;
      end else begin : g_rest
        assign prev_take[gi] = take[gi-1];
        assign prev_ents[gi] = ents[gi-1];
      end
      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign next_ents[gi] = '0;
      end else begin : g_inner
        assign next_ents[gi] = ents[gi+1];
      end
      rsit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .is_valid  (is_valid[gi]),
        .is_head   (gi == 0),
        .prev_take (prev_take[gi]),
        .prev_ent  (prev_ents[gi]),
        .next_ent  (next_ents[gi]),
        .take      (take[gi]),
        .ent       (ents[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    count_next = count;
    rank_next  = rank;
    unique case (state)
      ST_IDLE: begin
        rank_next = '0;
        if (do_ins && count < CountW'(TABLE_DEPTH)) begin
          count_next = count + 1'b1;
        end
        if (accept && emit_req && (do_ins || count != '0)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          count_next = count - 1'b1;
          rank_next  = rank + 1'b1;
          if (count == CountW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rank  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.ap_id_out    <= ents[0].ap_id;
      out_word.strength_out <= ents[0].strength;
      out_word.rank         <= rank;
      out_word.final_res    <= (count == CountW'(1));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> count != '0)
    else $error("draining an empty table");

  a_out_rank: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && out_word.rank == $past(rank))
    else $error("output word rank mismatch");

endmodule

>>> design/rsit_cell.sv
// one table slot: compare against the new record, insert, shift right or drain left
module rsit_cell
  import rsit_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      is_valid,
  input  logic      is_head,
  input  logic      prev_take,
  input  entry_t    prev_ent,
  input  entry_t    next_ent,
  output logic      take,
  output entry_t    ent
);

  logic cond;

  always_comb begin
    if (is_head) begin
      cond = ent.strength < ctl.new_ent.strength;
    end else begin
      cond = ent.strength <= ctl.new_ent.strength;
    end
    take = !is_valid || cond;
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_take) begin
        ent <= prev_ent;
      end else if (take) begin
        ent <= ctl.new_ent;
      end
    end else if (ctl.drain) begin
      ent <= next_ent;
    end
  end

endmodule

>>> tb/testbench.sv
// testbench for the descending sorted insert table: directed table, then random insert batches
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsit_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 200000;
  localparam int RAND_ITEMS = 160;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;

  typedef enum {BY_MODEL, NO_WORD, ONE_WORD} exp_kind_t;

  typedef struct {
    in_word_t  w;
    exp_kind_t kind;
    out_word_t exp;
  } row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  entry_t    shadow_tbl [TABLE_DEPTH];
  int        shadow_fill;
  out_word_t pending_words [$];
  int        errors;
  int        snd_idle;
  int        rcv_idle;
  bit        hold_req;
  int        cyc;

  rssi_sorted_insert_table_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic row_t row(logic [1:0] c, int s, int id, exp_kind_t k,
                               int eid = 0, int es = 0);
    row_t r;
    r.w.cmd = c;
    r.w.strength = s[7:0];
    r.w.ap_id = id[7:0];
    r.kind = k;
    r.exp.ap_id_out = eid[7:0];
    r.exp.strength_out = es[7:0];
    r.exp.rank = '0;
    r.exp.final_res = 1'b1;
    return r;
  endfunction

  // insert and/or drain the shadow table, queueing the words a drain sends out
  function automatic void sort_table_step(in_word_t w, bit queue_out);
    logic signed [7:0] s;
    logic signed [7:0] hs;
    int pos;
    int last;
    entry_t e;
    out_word_t o;
    s = w.strength;
    if (w.cmd == CMD_INSERT || w.cmd == CMD_INSERT_EMIT) begin
      hs = shadow_tbl[0].strength;
      if (shadow_fill == 0 || hs < s) begin
        pos = 0;
      end else begin
        pos = 1;
        while (pos < shadow_fill && $signed(shadow_tbl[pos].strength) > s) pos++;
      end
      if (pos < TABLE_DEPTH) begin
        e.strength = s;
        e.ap_id = w.ap_id;
        last = (shadow_fill < TABLE_DEPTH) ? shadow_fill : TABLE_DEPTH - 1;
        for (int i = last; i > pos; i--) shadow_tbl[i] = shadow_tbl[i-1];
        shadow_tbl[pos] = e;
        if (shadow_fill < TABLE_DEPTH) shadow_fill++;
      end
    end
    if (w.cmd != CMD_INSERT) begin
      for (int i = 0; i < shadow_fill; i++) begin
        o.ap_id_out = shadow_tbl[i].ap_id;
        o.strength_out = shadow_tbl[i].strength;
        o.rank = RankW'(i);
        o.final_res = (i == shadow_fill - 1);
        if (queue_out) pending_words.push_back(o);
      end
      shadow_fill = 0;
    end
  endfunction

  task automatic send_word(in_word_t w, exp_kind_t k, out_word_t x);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    sort_table_step(w, k == BY_MODEL);
    if (k == ONE_WORD) pending_words.push_back(x);
  endtask

  initial begin
    row_t dir_q [$];
    in_word_t rand_q [$];
    in_word_t w;
    int kind;
    int len;
    int n;
    int sv;
    bit first;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    errors = 0;
    hold_req = 1'b0;
    snd_idle = 10;
    rcv_idle = 57;
    shadow_fill = 0;
    first = 1'b1;

    dir_q.push_back(row(CMD_EMIT, 0, 0, NO_WORD));
    dir_q.push_back(row(CMD_INSERT_EMIT, 127, 255, ONE_WORD, 255, 127));
    dir_q.push_back(row(CMD_INSERT_EMIT, -128, 0, ONE_WORD, 0, -128));
    dir_q.push_back(row(CMD_UNUSED, -1, 255, NO_WORD));
    dir_q.push_back(row(CMD_INSERT, 0, 1, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, 0, 2, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, 5, 3, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, -5, 4, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, 5, 5, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, -128, 6, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, 127, 7, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, -128, 8, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, 127, 9, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT_EMIT, 5, 10, BY_MODEL));
    dir_q.push_back(row(CMD_EMIT, -1, 255, NO_WORD));
    dir_q.push_back(row(CMD_INSERT, -1, 170, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, -1, 85, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, 1, 128, BY_MODEL));
    dir_q.push_back(row(CMD_UNUSED, 85, 170, BY_MODEL));
    dir_q.push_back(row(CMD_INSERT, -128, 255, BY_MODEL));
    dir_q.push_back(row(CMD_EMIT, 127, 0, ONE_WORD, 255, -128));
    dir_q.push_back(row(CMD_INSERT_EMIT, 0, 0, ONE_WORD, 0, 0));

    // insert batches ended by an insert-emit, emit or unused cmd, some overflow; plus lone random words
    while (rand_q.size() < RAND_ITEMS) begin
      kind = first ? 1 : int'($urandom_range(0, 9));
      first = 1'b0;
      if (kind == 0) begin
        w.cmd = 2'($urandom);
        w.strength = 8'($urandom);
        w.ap_id = 8'($urandom);
        rand_q.push_back(w);
      end else begin
        len = (kind == 1) ? int'($urandom_range(30, 40)) : int'($urandom_range(1, 8));
        for (int j = 0; j < len; j++) begin
          w.cmd = CMD_INSERT;
          w.ap_id = 8'($urandom);
          if (kind == 1 && j >= TABLE_DEPTH && $urandom_range(0, 1) == 1) begin
            w.strength = 8'sh80;
          end else if (kind == 1) begin
            sv = int'($urandom_range(0, 254)) - 127;
            w.strength = 8'(sv);
          end else if ($urandom_range(0, 1) == 1) begin
            sv = int'($urandom_range(0, 6)) - 3;
            w.strength = 8'(sv);
          end else begin
            w.strength = 8'($urandom);
          end
          rand_q.push_back(w);
        end
        n = int'($urandom_range(0, 3));
        w.cmd = (n < 2) ? CMD_INSERT_EMIT : (n == 2) ? CMD_EMIT : CMD_UNUSED;
        w.strength = 8'($urandom);
        w.ap_id = 8'($urandom);
        rand_q.push_back(w);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_q[i]) send_word(dir_q[i].w, dir_q[i].kind, dir_q[i].exp);

    hold_req = 1'b1;
    for (int i = 0; i < rand_q.size(); i++) begin
      if (i == rand_q.size() / 3) begin
        snd_idle = 57;
        rcv_idle = 10;
      end else if (i == 2 * rand_q.size() / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      send_word(rand_q[i], BY_MODEL, '0);
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int hold_left;
    bit hold_done;
    out_word_t x;
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word ap_id_out %0d rank %0d", out_word.ap_id_out, out_word.rank);
          errors++;
        end else begin
          x = pending_words.pop_front();
          if (out_word.ap_id_out !== x.ap_id_out) begin
            $error("ap_id_out expected %0d actual %0d", x.ap_id_out, out_word.ap_id_out);
            errors++;
          end
          if (out_word.strength_out !== x.strength_out) begin
            $error("strength_out expected %0d actual %0d", x.strength_out,
                   out_word.strength_out);
            errors++;
          end
          if (out_word.rank !== x.rank) begin
            $error("rank expected %0d actual %0d", x.rank, out_word.rank);
            errors++;
          end
          if (out_word.final_res !== x.final_res) begin
            $error("final_res expected %0d actual %0d", x.final_res, out_word.final_res);
            errors++;
          end
        end
      end
      // long stall so the row fills and the input backs up
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

endmodule
